/* src/erm_pkg.sv */
// package for the euler rotation matrix block: types, constants and tables
package erm_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NSTG = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

  localparam int AW = 16;   // angle width
  localparam int RW = 16;   // result width
  localparam int XW = 34;   // cordic x/y width, q2.30 plus headroom
  localparam int ZW = 32;   // cordic angle accumulator, q2.28

  localparam logic signed [16:0] FULL_TURN    = 17'sd23040;
  localparam logic signed [16:0] HALF_TURN    = 17'sd11520;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;
  localparam logic signed [17:0] DEG_TO_RAD_Q28 = 18'sd73204;
  localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = XW'(652032874);
  localparam logic signed [RW-1:0] ONE_Q14 = 16'sd16384;

  typedef logic signed [AW-1:0] angle_t;
  typedef logic signed [RW-1:0] q14_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } cordic_t;

  function automatic logic signed [ZW-1:0] atan_q28(input int i);
    logic signed [ZW-1:0] tab [ATAN_ENTRIES];
    tab = '{32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
            32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
            32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072,
            32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192, 32'sd4096,
            32'sd2048, 32'sd1024, 32'sd512, 32'sd256, 32'sd128, 32'sd64,
            32'sd32};
    return tab[i];
  endfunction

  // clamp a wide signed value to [-1, +1] q2.14
  function automatic q14_t clamp_one(input logic signed [47:0] v);
    if (v > 48'sd16384) return ONE_Q14;
    if (v < -48'sd16384) return -ONE_Q14;
    return v[RW-1:0];
  endfunction

endpackage

/* src/erm_sincos.sv */
// pipelined cordic sine/cosine of one angle in degrees
module erm_sincos (
  input  logic          clk_i,
  input  logic          en_i,
  input  erm_pkg::angle_t angle_i,
  output erm_pkg::q14_t sin_o,
  output erm_pkg::q14_t cos_o
);
  import erm_pkg::*;

  // stage 0: range reduction, modulo by compare and subtract
  logic signed [16:0] r0;
  logic signed [16:0] r1;
  logic               neg1;
  always_comb begin
    r0 = 17'(angle_i);
    if (r0 >= FULL_TURN) r0 = r0 - FULL_TURN;
    else if (r0 <= -FULL_TURN) r0 = r0 + FULL_TURN;
    if (r0 < 0) r0 = r0 + FULL_TURN;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1 <= (r0 >= HALF_TURN);
      r1   <= (r0 >= HALF_TURN) ? (r0 - HALF_TURN - QUARTER_TURN) : (r0 - QUARTER_TURN);
    end
  end

  // stage 1: degrees to q2.28 radians, then cordic stages, one per register
  cordic_t c_q [NSTG+1];
  logic signed [35:0] zprod;
  assign zprod = 36'(r1) * 36'(DEG_TO_RAD_Q28);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q[0].x   <= CORDIC_GAIN_Q30;
      c_q[0].y   <= '0;
      c_q[0].z   <= zprod[ZW-1:0];
      c_q[0].neg <= neg1;
      for (int i = 0; i < NSTG; i++) begin
        c_q[i+1].neg <= c_q[i].neg;
        if (!c_q[i].z[ZW-1]) begin
          c_q[i+1].x <= c_q[i].x - (c_q[i].y >>> i);
          c_q[i+1].y <= c_q[i].y + (c_q[i].x >>> i);
          c_q[i+1].z <= c_q[i].z - atan_q28(i);
        end else begin
          c_q[i+1].x <= c_q[i].x + (c_q[i].y >>> i);
          c_q[i+1].y <= c_q[i].y - (c_q[i].x >>> i);
          c_q[i+1].z <= c_q[i].z + atan_q28(i);
        end
      end
    end
  end

  // output rounding: sin(r) = cos(t), cos(r) = -sin(t)
  logic signed [XW-1:0] xr, yr;
  q14_t s, c;
  assign xr = (c_q[NSTG].x + XW'(32768)) >>> 16;
  assign yr = (c_q[NSTG].y + XW'(32768)) >>> 16;
  assign s  = clamp_one(48'(xr));
  assign c  = -clamp_one(48'(yr));
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= c_q[NSTG].neg ? -s : s;
      cos_o <= c_q[NSTG].neg ? -c : c;
    end
  end
endmodule

/* src/euler_rotation_matrix.sv */
// top level: euler angle x-y-z rotation matrix, fully pipelined
// Takes one beat of three angles (degrees, 6 fraction bits) per cycle while
// not stalled and returns the nine q2.14 entries of Rx*Ry*Rz. The block
// accepts a new beat every cycle; the pipe is reduction, radians, cordic
// stages, rounding, two product stages, final rounding and clamp.
// The whole pipe advances when the output register is empty or taken, so
// a stall on the result side holds every stage in place.
module euler_rotation_matrix (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid,
  output logic           in_stall,
  input  erm_pkg::angle_t angle_x_i,
  input  erm_pkg::angle_t angle_y_i,
  input  erm_pkg::angle_t angle_z_i,
  output logic           out_valid,
  input  logic           out_stall,
  output erm_pkg::q14_t  r00_o,
  output erm_pkg::q14_t  r01_o,
  output erm_pkg::q14_t  r02_o,
  output erm_pkg::q14_t  r10_o,
  output erm_pkg::q14_t  r11_o,
  output erm_pkg::q14_t  r12_o,
  output erm_pkg::q14_t  r20_o,
  output erm_pkg::q14_t  r21_o,
  output erm_pkg::q14_t  r22_o
);
  import erm_pkg::*;

  localparam int LAT = NSTG + 6;

  // pipe advances unless a held result is not taken
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // valid bits travel with the data
  logic [LAT-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid};
    end
  end
  assign out_valid = vld_q[LAT-1];

  q14_t sx, cx, sy, cy, sz, cz;
  erm_sincos u_x (.clk_i, .en_i(en), .angle_i(angle_x_i), .sin_o(sx), .cos_o(cx));
  erm_sincos u_y (.clk_i, .en_i(en), .angle_i(angle_y_i), .sin_o(sy), .cos_o(cy));
  erm_sincos u_z (.clk_i, .en_i(en), .angle_i(angle_z_i), .sin_o(sz), .cos_o(cz));

  // first products, q.28
  logic signed [31:0] cycz_q, cysz_q, sxsy_q, cxsz_q, cxcz_q, sxcy_q, sxsz_q;
  logic signed [31:0] cxsy_q, sxcz_q, cxcy_q;
  q14_t sy_q, cz_q, sz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      cycz_q <= 32'(cy) * 32'(cz);
      cysz_q <= 32'(cy) * 32'(sz);
      sxsy_q <= 32'(sx) * 32'(sy);
      cxsz_q <= 32'(cx) * 32'(sz);
      cxcz_q <= 32'(cx) * 32'(cz);
      sxcy_q <= 32'(sx) * 32'(cy);
      sxsz_q <= 32'(sx) * 32'(sz);
      cxsy_q <= 32'(cx) * 32'(sy);
      sxcz_q <= 32'(sx) * 32'(cz);
      cxcy_q <= 32'(cx) * 32'(cy);
      sy_q <= sy; cz_q <= cz; sz_q <= sz;
    end
  end

  // second products and sums, q.42
  logic signed [47:0] e_q [9];
  q14_t sy2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q[0] <= 48'(cycz_q) <<< 14;
      e_q[1] <= -(48'(cysz_q) <<< 14);
      e_q[3] <= 48'(sxsy_q) * 48'(cz_q) + (48'(cxsz_q) <<< 14);
      e_q[4] <= (48'(cxcz_q) <<< 14) - 48'(sxsy_q) * 48'(sz_q);
      e_q[5] <= -(48'(sxcy_q) <<< 14);
      e_q[6] <= (48'(sxsz_q) <<< 14) - 48'(cxsy_q) * 48'(cz_q);
      e_q[7] <= (48'(sxcz_q) <<< 14) + 48'(cxsy_q) * 48'(sz_q);
      e_q[8] <= 48'(cxcy_q) <<< 14;
      e_q[2] <= '0;
      sy2_q  <= sy_q;
    end
  end

  // round and clamp
  function automatic q14_t rnd(input logic signed [47:0] v);
    return clamp_one((v + 48'sd134217728) >>> 28);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      r00_o <= rnd(e_q[0]);
      r01_o <= rnd(e_q[1]);
      r02_o <= (e_q[2] == '0) ? sy2_q : sy2_q;
      r10_o <= rnd(e_q[3]);
      r11_o <= rnd(e_q[4]);
      r12_o <= rnd(e_q[5]);
      r20_o <= rnd(e_q[6]);
      r21_o <= rnd(e_q[7]);
      r22_o <= rnd(e_q[8]);
    end
  end

  // a held result must stay valid
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid)
    else $error("result lost under stall");
  // stall only when the output is full
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall |-> out_valid)
    else $error("stall without held result");
  // entries r00 and r11 stay within plus or minus one
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (r00_o <= ONE_Q14 && r00_o >= -ONE_Q14 &&
                   r11_o <= ONE_Q14 && r11_o >= -ONE_Q14))
    else $error("entry out of range");
endmodule

/* sim/euler_rotation_matrix_test.sv */
// testbench for the euler rotation matrix block: angle stimulus, predictor and result check
`timescale 1ns / 1ps
module euler_rotation_matrix_test;
  import erm_pkg::*;

  localparam int LATENCY   = CORDIC_STAGES + 6;
  localparam int N_RANDOM  = 1150;
  localparam int IDLE_LIMIT = 20000;

  // one result beat, r00..r22 in row order
  typedef struct {
    q14_t e [9];
  } rot_mat_t;

  // one directed stimulus row; check_known set when the expected matrix is typed in
  typedef struct {
    angle_t ax;
    angle_t ay;
    angle_t az;
    bit     check_known;
    q14_t   known [9];
  } angle_row_t;

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid;
  logic   in_stall;
  angle_t angle_x_i, angle_y_i, angle_z_i;
  logic   out_valid;
  logic   out_stall;
  q14_t   r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o;

  euler_rotation_matrix dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall),
    .angle_x_i(angle_x_i), .angle_y_i(angle_y_i), .angle_z_i(angle_z_i),
    .out_valid(out_valid), .out_stall(out_stall),
    .r00_o(r00_o), .r01_o(r01_o), .r02_o(r02_o),
    .r10_o(r10_o), .r11_o(r11_o), .r12_o(r12_o),
    .r20_o(r20_o), .r21_o(r21_o), .r22_o(r22_o)
  );

  rot_mat_t pending_mats [$];
  int       fail_count;
  int       idle_cycles;
  bit       stim_done;
  bit       hold_off;   // long receiver stall, set once by the stimulus process

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // predictor: sine/cosine by cordic, then the product Rx*Ry*Rz
  // ---------------------------------------------------------------------
  function automatic longint sra64(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint sat_unit(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  localparam longint ATAN_TAB [24] = '{
    210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
    4193963, 2097109, 1048571, 524287, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

  function automatic void angle_sin_cos(input angle_t a, output longint s,
                                        output longint c);
    longint r, x, y, z, nx;
    bit flip;
    int nst;
    r = longint'(a) % 23040;
    if (r < 0) r += 23040;
    flip = 1'b0;
    // second half turn folds onto the first with both signs flipped
    if (r >= 11520) begin
      r -= 11520;
      flip = 1'b1;
    end
    z = (r - 5760) * 73204;
    x = 652032874;
    y = 0;
    nst = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
    for (int i = 0; i < nst; i++) begin
      if (z >= 0) begin
        nx = x - sra64(y, i);
        y  = y + sra64(x, i);
        z  = z - ATAN_TAB[i];
      end else begin
        nx = x + sra64(y, i);
        y  = y - sra64(x, i);
        z  = z + ATAN_TAB[i];
      end
      x = nx;
    end
    // t = r - 90 deg, so sin(r) = cos(t) and cos(r) = -sin(t)
    s = sat_unit(sra64(x + 32768, 16));
    c = -sat_unit(sra64(y + 32768, 16));
    if (flip) begin
      s = -s;
      c = -c;
    end
  endfunction

  function automatic q14_t round_entry(longint v);
    return q14_t'(sat_unit(sra64(v + (longint'(1) << 27), 28)));
  endfunction

  function automatic rot_mat_t rotation_of(angle_t ax, angle_t ay, angle_t az);
    rot_mat_t m;
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    angle_sin_cos(ax, sx, cx);
    angle_sin_cos(ay, sy, cy);
    angle_sin_cos(az, sz, cz);
    sxsy = sx * sy;
    cxsy = cx * sy;
    m.e[0] = round_entry(cy * cz * 16384);
    m.e[1] = round_entry(-cy * sz * 16384);
    m.e[2] = q14_t'(sy);
    m.e[3] = round_entry(sxsy * cz + cx * sz * 16384);
    m.e[4] = round_entry(cx * cz * 16384 - sxsy * sz);
    m.e[5] = round_entry(-sx * cy * 16384);
    m.e[6] = round_entry(sx * sz * 16384 - cxsy * cz);
    m.e[7] = round_entry(sx * cz * 16384 + cxsy * sz);
    m.e[8] = round_entry(cx * cy * 16384);
    return m;
  endfunction

  // short gaps mostly, a few long ones
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // ---------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------
  angle_row_t angle_rows [$];

  function automatic angle_row_t mk_row(int ax, int ay, int az);
    angle_row_t r;
    r.ax = angle_t'(ax);
    r.ay = angle_t'(ay);
    r.az = angle_t'(az);
    r.check_known = 1'b0;
    return r;
  endfunction

  // identity-like rows whose matrices are read off at a glance
  function automatic angle_row_t mk_known(int ax, int ay, int az, q14_t k [9]);
    angle_row_t r;
    r = mk_row(ax, ay, az);
    r.check_known = 1'b1;
    r.known = k;
    return r;
  endfunction

  task automatic send_beat(input angle_t ax, input angle_t ay, input angle_t az);
    in_valid  <= 1'b1;
    angle_x_i <= ax;
    angle_y_i <= ay;
    angle_z_i <= az;
    pending_mats.push_back(rotation_of(ax, ay, az));
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    q14_t ident [9];
    rot_mat_t m;
    int mode;
    int ax, ay, az;
    in_valid  <= 1'b0;
    angle_x_i <= '0;
    angle_y_i <= '0;
    angle_z_i <= '0;
    stim_done = 1'b0;
    hold_off  = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    ident = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};
    angle_rows.push_back(mk_known(0, 0, 0, ident));
    // full turn and its negative wrap to zero
    angle_rows.push_back(mk_known(23040, 0, 0, ident));
    angle_rows.push_back(mk_known(0, -23040, 23040, ident));
    angle_rows.push_back(mk_row(32767, 32767, 32767));
    angle_rows.push_back(mk_row(-32768, -32768, -32768));
    angle_rows.push_back(mk_row(32767, -32768, 0));
    angle_rows.push_back(mk_row(-1, -1, -1));
    angle_rows.push_back(mk_row(1, 1, 1));
    angle_rows.push_back(mk_row(5760, 0, 0));
    angle_rows.push_back(mk_row(0, 5760, 0));
    angle_rows.push_back(mk_row(0, 0, 5760));
    angle_rows.push_back(mk_row(11520, 11520, 11520));
    angle_rows.push_back(mk_row(11519, 11521, 17280));
    angle_rows.push_back(mk_row(-5760, -11520, -17280));
    angle_rows.push_back(mk_row(2880, 2880, 2880));
    angle_rows.push_back(mk_row(5759, 5761, 23039));
    angle_rows.push_back(mk_row(-23041, 23041, 21760));
    // r01 carries -sin(z)*cos(y)
    angle_rows.push_back(mk_row(0, 1920, 3840));
    angle_rows.push_back(mk_row(16'h5555, 16'h2AAA, -16'sh5556));

    foreach (angle_rows[i]) begin
      send_beat(angle_rows[i].ax, angle_rows[i].ay, angle_rows[i].az);
      if (angle_rows[i].check_known) begin
        m = pending_mats[$];
        foreach (m.e[k])
          if (m.e[k] !== angle_rows[i].known[k]) begin
            $display("%0t predictor row %0d entry %0d expected %0d actual %0d",
                     $time, i, k, angle_rows[i].known[k], m.e[k]);
            fail_count++;
          end
        pending_mats[$].e = angle_rows[i].known;
      end
      idle_for(gap_len());
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      // long receiver hold-off while the sender keeps offering beats
      if (n == 300) hold_off = 1'b1;
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        ax = $urandom_range(0, 65535);
        ay = $urandom_range(0, 65535);
        az = $urandom_range(0, 65535);
      end else if (mode < 9) begin
        // near the quarter-turn folds, where sign flips happen
        ax = 5760 * $urandom_range(0, 11) - 5760 * 6 + $urandom_range(0, 4) - 2;
        ay = 5760 * $urandom_range(0, 11) - 5760 * 6 + $urandom_range(0, 4) - 2;
        az = 5760 * $urandom_range(0, 11) - 5760 * 6 + $urandom_range(0, 4) - 2;
      end else begin
        ax = $urandom_range(0, 1) ? 32767 : -32768;
        ay = $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535);
        az = $urandom_range(0, 1) ? -32768 : 32767;
      end
      send_beat(angle_t'(ax), angle_t'(ay), angle_t'(az));
      if ($urandom_range(0, 3) == 0) idle_for(gap_len());
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------------
  // receiver: random stall, one long hold-off
  // ---------------------------------------------------------------------
  initial begin
    int n;
    out_stall <= 1'b1;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_stall <= 1'b1;
        repeat (LATENCY * 4 + 60) @(posedge clk_i);
      end
      n = gap_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------
  // result check and watchdog
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    rot_mat_t want;
    q14_t got [9];
    if (rst_ni && out_valid && !out_stall) begin
      got = '{r00_o, r01_o, r02_o, r10_o, r11_o, r12_o, r20_o, r21_o, r22_o};
      if (pending_mats.size() == 0) begin
        $display("%0t unexpected result beat r00=%0d", $time, r00_o);
        fail_count++;
      end else begin
        want = pending_mats.pop_front();
        foreach (got[k])
          if (got[k] !== want.e[k]) begin
            $display("%0t entry r%0d%0d expected %0d actual %0d",
                     $time, k / 3, k % 3, want.e[k], got[k]);
            fail_count++;
          end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // watchdog over the whole run
  always @(posedge clk_i) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    fail_count = 0;
    idle_cycles = 0;
    wait (stim_done);
    while (pending_mats.size() != 0) @(posedge clk_i);
    // drain window: any extra beat shows up here
    repeat (LATENCY * 3 + 50) @(posedge clk_i);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* files.f */
src/erm_pkg.sv
src/erm_sincos.sv
src/euler_rotation_matrix.sv
sim/euler_rotation_matrix_test.sv
